@@ hw/rtl/bcpd_pkg.sv @@
package bcpd_pkg;

  localparam int BTN_W   = 5;
  localparam int LEVEL_W = 8;
  localparam int MASK_W  = 3;
  localparam int SELO_W  = 2;

  // bit positions inside the button field
  localparam int BTN_RIGHT = 0;
  localparam int BTN_LEFT  = 1;
  localparam int BTN_DOWN  = 2;
  localparam int BTN_UP    = 3;
  localparam int BTN_PUSH  = 4;

  localparam logic [LEVEL_W-1:0] PERIOD_RESET = 8'd20;

  typedef struct packed {
    logic [MASK_W-1:0] led_mask;
    logic [SELO_W-1:0] sel;
  } result_t;

endpackage

@@ hw/rtl/bcpd_ctrl.sv @@
module bcpd_ctrl #(
  parameter int NUM_CHANNELS = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [bcpd_pkg::BTN_W-1:0]   buttons,
  input  logic [bcpd_pkg::LEVEL_W-1:0] period,
  output bcpd_pkg::result_t            res_nxt
);
  import bcpd_pkg::*;

  localparam int SEL_W = $clog2(NUM_CHANNELS);
  localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(NUM_CHANNELS - 1);

  logic [LEVEL_W-1:0] tick_r, tick_nxt;
  logic [LEVEL_W-1:0] level_r [NUM_CHANNELS];
  logic [LEVEL_W-1:0] level_nxt [NUM_CHANNELS];
  logic [SEL_W-1:0]   sel_r, sel_nxt;
  logic               left_held_r, left_held_nxt;
  logic               right_held_r, right_held_nxt;

  logic                    serve;
  logic                    do_up, do_down, do_left, do_right, do_push;
  logic [NUM_CHANNELS-1:0] mask;
  logic [31:0]             mask_ext;
  logic [31:0]             sel_ext;

  // priority: up, down, left, right, push
  assign do_up    = buttons[BTN_UP];
  assign do_down  = !buttons[BTN_UP] && buttons[BTN_DOWN];
  assign do_left  = !buttons[BTN_UP] && !buttons[BTN_DOWN] && buttons[BTN_LEFT];
  assign do_right = !buttons[BTN_UP] && !buttons[BTN_DOWN] && !buttons[BTN_LEFT]
                    && buttons[BTN_RIGHT];
  assign do_push  = !buttons[BTN_UP] && !buttons[BTN_DOWN] && !buttons[BTN_LEFT]
                    && !buttons[BTN_RIGHT] && buttons[BTN_PUSH];

  // a count above a lowered period counts as reaching it
  assign serve = (tick_r >= period);

  always_comb begin
    tick_nxt       = serve ? '0 : tick_r + 8'd1;
    sel_nxt        = sel_r;
    left_held_nxt  = left_held_r;
    right_held_nxt = right_held_r;
    if (serve) begin
      left_held_nxt  = do_left;
      right_held_nxt = do_right;
      if (do_left && !left_held_r) begin
        sel_nxt = (sel_r == '0) ? SEL_LAST : sel_r - 1'b1;
      end else if (do_right && !right_held_r) begin
        sel_nxt = (sel_r == SEL_LAST) ? '0 : sel_r + 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      level_nxt[i] = level_r[i];
      if (serve) begin
        if (do_up && sel_r == SEL_W'(i)) begin
          level_nxt[i] = (level_r[i] < period) ? level_r[i] + 8'd1 : period;
        end else if (do_down && sel_r == SEL_W'(i) && level_r[i] != '0) begin
          level_nxt[i] = level_r[i] - 8'd1;
        end else if (do_push) begin
          level_nxt[i] = '0;
        end
      end
      mask[i] = (tick_nxt < level_nxt[i]);
    end
  end

  // only the low channels fit the result fields
  assign mask_ext         = 32'(mask);
  assign sel_ext          = 32'(sel_nxt);
  assign res_nxt.led_mask = mask_ext[MASK_W-1:0];
  assign res_nxt.sel      = sel_ext[SELO_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r       <= '0;
      sel_r        <= '0;
      left_held_r  <= 1'b0;
      right_held_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        level_r[i] <= '0;
      end
    end else if (step) begin
      tick_r       <= tick_nxt;
      sel_r        <= sel_nxt;
      left_held_r  <= left_held_nxt;
      right_held_r <= right_held_nxt;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        level_r[i] <= level_nxt[i];
      end
    end
  end

endmodule

@@ hw/rtl/button_controlled_pwm_dimmer.sv @@
// channel | ports                                    | direction
// in      | in_valid, in_ready, in_buttons_pressed   | tick into block
// out     | out_valid, out_ready, out_led_mask,      | one result per tick
//         | out_selected_channel                     |
// cfg     | cfg_wr_en, cfg_wr_data                   | pwm period write
//
// one tick per cycle: the state update and led compare sit between the state
// registers and the result register, so a tick's result shows in the cycle
// after its transaction. reset is synchronous and clears levels, count,
// selection and held flags; the period returns to 20. a full result register
// that is not taken holds in_ready low; once out_ready is high a new tick
// enters in the same cycle the old result leaves.
module button_controlled_pwm_dimmer #(
  parameter int NUM_CHANNELS = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bcpd_pkg::BTN_W-1:0]   in_buttons_pressed,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bcpd_pkg::MASK_W-1:0]  out_led_mask,
  output logic [bcpd_pkg::SELO_W-1:0]  out_selected_channel,
  input  logic                         cfg_wr_en,
  input  logic [bcpd_pkg::LEVEL_W-1:0] cfg_wr_data
);
  import bcpd_pkg::*;

  logic [LEVEL_W-1:0] period_r;
  logic               out_valid_r;
  result_t            res_r;
  result_t            res_nxt;
  logic               accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  bcpd_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (accept),
    .buttons (in_buttons_pressed),
    .period  (period_r),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_wr_en) begin
      period_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_led_mask         = res_r.led_mask;
  assign out_selected_channel = res_r.sel;

endmodule

@@ hw/rtl/bcpd_checker.sv @@
module bcpd_checker #(
  parameter int NUM_CHANNELS = 3
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bcpd_pkg::MASK_W-1:0]  out_led_mask,
  input logic [bcpd_pkg::SELO_W-1:0]  out_selected_channel
);
  import bcpd_pkg::*;

  // every accepted tick yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after accepted transaction");

  // a stalled result blocks new ticks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_led_mask)
      && $stable(out_selected_channel))
    else $error("stalled result changed");

  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_selected_channel) < NUM_CHANNELS)
    else $error("selected channel out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind button_controlled_pwm_dimmer bcpd_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_bcpd_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_led_mask         (out_led_mask),
  .out_selected_channel (out_selected_channel)
);

@@ bench/testbench.sv @@
module testbench;

  import bcpd_pkg::*;

  localparam int CHANNELS    = 3;
  localparam int CYCLE_LIMIT = 200000;

  logic                clk                  = 1'b0;
  logic                rst_n                = 1'b0;
  logic                in_valid             = 1'b0;
  logic                in_ready;
  logic [BTN_W-1:0]    in_buttons_pressed   = '0;
  logic                out_valid;
  logic                out_ready            = 1'b0;
  logic [MASK_W-1:0]   out_led_mask;
  logic [SELO_W-1:0]   out_selected_channel;
  logic                cfg_wr_en            = 1'b0;
  logic [LEVEL_W-1:0]  cfg_wr_data          = '0;

  // pending button ticks and the dimmer outputs they must produce
  logic [BTN_W-1:0]    pending_ticks[$];
  result_t             expected_outputs[$];

  // dimmer state as predicted
  logic [LEVEL_W-1:0]  mdl_period = PERIOD_RESET;
  logic [LEVEL_W-1:0]  mdl_count;
  logic [LEVEL_W-1:0]  mdl_level[CHANNELS];
  logic [1:0]          mdl_sel;
  logic                mdl_left_held;
  logic                mdl_right_held;

  int                  error_count = 0;
  int                  cycle_count = 0;
  int                  send_gap    = 0;
  int                  take_stall  = 0;
  bit                  no_idle     = 1'b0;
  result_t             predicted;
  result_t             want;

  button_controlled_pwm_dimmer #(
    .NUM_CHANNELS(CHANNELS)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_buttons_pressed  (in_buttons_pressed),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_led_mask        (out_led_mask),
    .out_selected_channel(out_selected_channel),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  always #10 clk = ~clk;

  // one pwm tick: advance the counter, serve buttons at wrap, compare levels
  task automatic dimmer_tick(input logic [BTN_W-1:0] b, output result_t r);
    logic [1:0]        s;
    logic              nl;
    logic              nr;
    logic [MASK_W-1:0] mask;
    s    = mdl_sel;
    nl   = 1'b0;
    nr   = 1'b0;
    mask = '0;
    if (mdl_count >= mdl_period) begin
      if (b[BTN_UP]) begin
        if (mdl_level[s] < mdl_period) mdl_level[s] = mdl_level[s] + 1'b1;
        else mdl_level[s] = mdl_period;
      end else if (b[BTN_DOWN]) begin
        if (mdl_level[s] > 0) mdl_level[s] = mdl_level[s] - 1'b1;
      end else if (b[BTN_LEFT]) begin
        if (!mdl_left_held) s = (s > 0) ? s - 1'b1 : 2'(CHANNELS - 1);
        nl = 1'b1;
      end else if (b[BTN_RIGHT]) begin
        if (!mdl_right_held) s = (s < CHANNELS - 1) ? s + 1'b1 : 2'd0;
        nr = 1'b1;
      end else if (b[BTN_PUSH]) begin
        for (int i = 0; i < CHANNELS; i++) mdl_level[i] = '0;
      end
      mdl_sel        = s;
      mdl_left_held  = nl;
      mdl_right_held = nr;
      mdl_count      = '0;
    end else begin
      mdl_count = mdl_count + 1'b1;
    end
    for (int i = 0; i < CHANNELS; i++) begin
      if (mdl_count < mdl_level[i]) mask[i] = 1'b1;
    end
    r.led_mask = mask;
    r.sel      = mdl_sel;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        dimmer_tick(in_buttons_pressed, predicted);
        expected_outputs.push_back(predicted);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        in_buttons_pressed <= pending_ticks.pop_front();
        in_valid <= 1'b1;
        send_gap = no_idle ? 0 : $urandom_range(0, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      take_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_outputs.size() == 0) begin
          $error("unexpected transaction: led_mask %0h selected_channel %0d",
                 out_led_mask, out_selected_channel);
          error_count++;
        end else begin
          want = expected_outputs.pop_front();
          if (out_led_mask !== want.led_mask) begin
            $error("led_mask expected %0h actual %0h", want.led_mask, out_led_mask);
            error_count++;
          end
          if (out_selected_channel !== want.sel) begin
            $error("selected_channel expected %0d actual %0d", want.sel,
                   out_selected_channel);
            error_count++;
          end
        end
        take_stall = no_idle ? 0 : $urandom_range(0, 9);
      end else if (take_stall > 0) begin
        take_stall--;
      end
      out_ready <= (take_stall == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic wait_idle;
    do @(posedge clk);
    while (pending_ticks.size() != 0 || in_valid || expected_outputs.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_period(input logic [LEVEL_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    mdl_period = value;
  endtask

  // mostly single buttons held for runs of ticks, some idle and some chords
  task automatic random_ticks(input int n);
    int               k;
    int               run;
    logic [BTN_W-1:0] b;
    while (n > 0) begin
      k = $urandom_range(0, 15);
      case (k)
        0, 1:        b = '0;
        2, 3:        b = BTN_W'(1) << BTN_RIGHT;
        4, 5:        b = BTN_W'(1) << BTN_LEFT;
        6, 7:        b = BTN_W'(1) << BTN_DOWN;
        8, 9, 10, 11: b = BTN_W'(1) << BTN_UP;
        12:          b = BTN_W'(1) << BTN_PUSH;
        default:     b = BTN_W'($urandom_range(0, 31));
      endcase
      run = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
      while (run > 0 && n > 0) begin
        pending_ticks.push_back(b);
        run--;
        n--;
      end
    end
  endtask

  task automatic run_phase(input logic [LEVEL_W-1:0] period, input int n, input bit quiet);
    wait_idle();
    write_period(period);
    no_idle = quiet;
    random_ticks(n);
  endtask

  initial begin
    logic [BTN_W-1:0] directed[13];
    mdl_count      = '0;
    mdl_sel        = '0;
    mdl_left_held  = 1'b0;
    mdl_right_held = 1'b0;
    for (int i = 0; i < CHANNELS; i++) mdl_level[i] = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // period 1 serves every other tick, so each value goes in twice
    directed = '{5'b00000, 5'b01000, 5'b01000, 5'b00100, 5'b00100, 5'b00010,
                 5'b00010, 5'b00000, 5'b00001, 5'b00001, 5'b11111, 5'b10011,
                 5'b10000};
    write_period(8'd1);
    foreach (directed[i]) begin
      pending_ticks.push_back(directed[i]);
      pending_ticks.push_back(directed[i]);
    end

    run_phase(8'd0, 150, 1'b0);
    run_phase(8'd3, 100, 1'b1);
    // sender holds off until the block has drained
    wait_idle();
    random_ticks(100);
    run_phase(8'd255, 300, 1'b0);
    run_phase(8'd2, 150, 1'b0);
    run_phase(8'd15, 150, 1'b0);
    // levels left above the new period
    run_phase(8'd4, 100, 1'b0);
    run_phase(8'd1, 150, 1'b1);
    run_phase(LEVEL_W'($urandom_range(1, 31)), 150, 1'b0);

    wait_idle();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
